>>> hw/rtl/dirty_rect_coalescer_top_assert.svh
// Assertion macros for the dirty rect coalescer RTL (included by drc_back).
// Expects clk and rst (active high, synchronous) in the including module.
`ifndef DIRTY_RECT_COALESCER_TOP_ASSERT_SVH
`define DIRTY_RECT_COALESCER_TOP_ASSERT_SVH

`define DRC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("drc: invariant violated");

`define DRC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drc: implication violated");

`define DRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drc: next-cycle check violated");

`endif

>>> hw/rtl/drc_pkg.sv
// Package for the dirty rect coalescer: rect/item/config types and codes.
// No dependencies.
package drc_pkg;

  localparam int OUT_LIMIT = 32;

  typedef struct packed {
    logic [13:0] l;
    logic [13:0] t;
    logic [13:0] r;
    logic [13:0] b;
  } rect_t;

  typedef struct packed {
    rect_t       rect;
    logic        store;
    logic        lme;
    logic        last;
    logic        force_req;
    logic        ovf_rec;
    logic [1:0]  reason;
  } item_t;

  typedef struct packed {
    logic [13:0] width;
    logic [13:0] height;
    logic        touch;
    logic [5:0]  max_cnt;
    logic [17:0] thr;
  } back_cfg_t;

  localparam logic [2:0] FB_NONE     = 3'd0;
  localparam logic [2:0] FB_INTENT   = 3'd1;
  localparam logic [2:0] FB_OVERFLOW = 3'd2;
  localparam logic [2:0] FB_REASON   = 3'd3;
  localparam logic [2:0] FB_EMPTY    = 3'd4;
  localparam logic [2:0] FB_COUNT    = 3'd5;
  localparam logic [2:0] FB_COVERAGE = 3'd6;

  localparam logic [1:0] REASON_TOPOLOGY = 2'd1;
  localparam logic [1:0] REASON_RECOVERY = 2'd2;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [2:0] REG_TOUCH     = 3'd4;
  localparam logic [2:0] REG_MAX_COUNT = 3'd5;
  localparam logic [2:0] REG_COV_THR   = 3'd6;

endpackage

>>> hw/rtl/drc_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module drc_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/drc_front.sv
// Front end: maps an incoming rect to monitor-local space, clips and classifies it.
// Depends on drc_pkg.
module drc_front import drc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic signed [COORD_BITS-1:0] rect_right,
  input  logic signed [COORD_BITS-1:0] rect_bottom,
  input  logic                         has_rect,
  input  logic                         last_rect,
  input  logic                         desktop_coords,
  input  logic                         explicit_target,
  input  logic                         force_request,
  input  logic                         overflow_recovery,
  input  logic [1:0]                   present_reason,
  input  logic [13:0]                  mon_width,
  input  logic [13:0]                  mon_height,
  input  logic signed [15:0]           mon_ox,
  input  logic signed [15:0]           mon_oy,
  input  logic                         push,
  input  logic                         q_full,
  output logic                         q_push,
  output item_t                        q_item
);

  localparam int AW = (COORD_BITS > 16 ? COORD_BITS : 16) + 2;

  logic signed [AW-1:0] l, t, r, b, ox, oy, w, h, oxw, oyh;
  logic signed [AW-1:0] ll, lt, lr, lb;

  assign l   = AW'(rect_left);
  assign t   = AW'(rect_top);
  assign r   = AW'(rect_right);
  assign b   = AW'(rect_bottom);
  assign ox  = AW'(mon_ox);
  assign oy  = AW'(mon_oy);
  assign w   = AW'(mon_width);
  assign h   = AW'(mon_height);
  assign oxw = ox + w;
  assign oyh = oy + h;

  always_comb begin
    if (desktop_coords) begin
      ll = ((l > ox) ? l : ox) - ox;
      lt = ((t > oy) ? t : oy) - oy;
      lr = ((r < oxw) ? r : oxw) - ox;
      lb = ((b < oyh) ? b : oyh) - oy;
    end else begin
      ll = (l > 0) ? l : '0;
      lt = (t > 0) ? t : '0;
      lr = (r < w) ? r : w;
      lb = (b < h) ? b : h;
    end
  end

  assign q_push = push && !q_full;

  always_comb begin
    q_item.rect.l    = ll[13:0];
    q_item.rect.t    = lt[13:0];
    q_item.rect.r    = lr[13:0];
    q_item.rect.b    = lb[13:0];
    q_item.store     = has_rect && (desktop_coords || explicit_target) &&
                       (ll < lr) && (lt < lb);
    q_item.lme       = has_rect && !desktop_coords && !explicit_target;
    q_item.last      = last_rect;
    q_item.force_req = force_request;
    q_item.ovf_rec   = overflow_recovery;
    q_item.reason    = present_reason;
  end

endmodule

>>> hw/rtl/drc_queue.sv
// Short queue of classified items between front and back end.
// Depends on drc_pkg.
module drc_queue import drc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign full    = (32'(fill) == DEPTH);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/drc_back.sv
// Back end: rect store, sort, merge passes, coverage test and result output.
// Depends on drc_pkg, drc_ram and dirty_rect_coalescer_top_assert.svh.
`include "dirty_rect_coalescer_top_assert.svh"
module drc_back import drc_pkg::*; #(
  parameter int MAX_RECTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  back_cfg_t   cfg,
  input  item_t       q_item,
  input  logic        q_empty,
  output logic        q_pop,
  output logic [13:0] out_left,
  output logic [13:0] out_top,
  output logic [13:0] out_right,
  output logic [13:0] out_bottom,
  output logic        out_last,
  output logic        full_frame,
  output logic [2:0]  fallback_code,
  output logic        empty,
  input  logic        pop
);

  localparam int IW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNTW = $clog2(MAX_RECTS + 1);
  localparam int COVW = 28 + CNTW;
  localparam int RW   = $bits(rect_t);

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_DECIDE = 22'h000002,
    S_SK     = 22'h000004,
    S_SKW    = 22'h000008,
    S_SRD    = 22'h000010,
    S_SCMP   = 22'h000020,
    S_PRD    = 22'h000040,
    S_PCUR   = 22'h000080,
    S_PSCAN  = 22'h000100,
    S_PHIT   = 22'h000200,
    S_PSHIFT = 22'h000400,
    S_PSHW   = 22'h000800,
    S_PEND   = 22'h001000,
    S_CRD    = 22'h002000,
    S_CMUL   = 22'h004000,
    S_CACC   = 22'h008000,
    S_AR1    = 22'h010000,
    S_AR2    = 22'h020000,
    S_CMP    = 22'h040000,
    S_FULL   = 22'h080000,
    S_ERD    = 22'h100000,
    S_EWR    = 22'h200000
  } state_t;

  function automatic logic rect_less(input rect_t a, input rect_t b);
    if (a.t != b.t) return a.t < b.t;
    if (a.l != b.l) return a.l < b.l;
    if (a.b != b.b) return a.b < b.b;
    return a.r < b.r;
  endfunction

  function automatic logic rect_hits(input rect_t a, input rect_t b, input logic touch);
    if (touch) return (a.l <= b.r) && (b.l <= a.r) && (a.t <= b.b) && (b.t <= a.b);
    return (a.l < b.r) && (b.l < a.r) && (a.t < b.b) && (b.t < a.b);
  endfunction

  function automatic rect_t rect_union(input rect_t a, input rect_t b);
    rect_t u;
    u.l = (a.l < b.l) ? a.l : b.l;
    u.t = (a.t < b.t) ? a.t : b.t;
    u.r = (a.r > b.r) ? a.r : b.r;
    u.b = (a.b > b.b) ? a.b : b.b;
    return u;
  endfunction

  state_t          state;
  logic [CNTW-1:0] cnt, n, i, j, k, m, jm1, kp1, mm1;
  logic            sovf, lme, changed, s;
  logic            ev_force, ev_ovf;
  logic [1:0]      ev_reason;
  rect_t           key, cur;
  logic [27:0]     prod, area;
  logic [45:0]     thr_area;
  logic [COVW-1:0] cov;
  logic [2:0]      code, code_dec;
  logic            ovalid, ofree, out_load, hit, less, too_many, cov_hit;

  logic [IW-1:0]   sra, dra, swa, dwa;
  logic            swe, dwe;
  rect_t           swd, dwd, src_rd, dst_rd;
  logic [RW-1:0]   rd0, rd1;

  drc_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_ram0 (
    .clk   (clk),
    .we    (s ? dwe : swe),
    .waddr (s ? dwa : swa),
    .wdata (s ? dwd : swd),
    .raddr (s ? dra : sra),
    .rdata (rd0)
  );

  drc_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_ram1 (
    .clk   (clk),
    .we    (s ? swe : dwe),
    .waddr (s ? swa : dwa),
    .wdata (s ? swd : dwd),
    .raddr (s ? sra : dra),
    .rdata (rd1)
  );

  assign src_rd = s ? rd1 : rd0;
  assign dst_rd = s ? rd0 : rd1;

  assign jm1      = j - 1'b1;
  assign kp1      = k + 1'b1;
  assign mm1      = m - 1'b1;
  assign ofree    = !ovalid || pop;
  assign out_load = ofree && ((state == S_FULL) || (state == S_EWR));
  assign empty    = !ovalid;
  assign hit      = rect_hits(cur, dst_rd, cfg.touch);
  assign less     = rect_less(key, src_rd);
  assign too_many = (32'(m) > 32'(cfg.max_cnt)) || (32'(m) > OUT_LIMIT);
  assign cov_hit  = (area == '0) ? (cfg.thr == '0) :
                    ((64'(cov) << 16) >= 64'(thr_area));

  always_comb begin
    if (lme) begin
      code_dec = FB_EMPTY;
    end else if (ev_force) begin
      code_dec = FB_INTENT;
    end else if (ev_ovf) begin
      code_dec = FB_OVERFLOW;
    end else if (ev_reason == REASON_TOPOLOGY || ev_reason == REASON_RECOVERY) begin
      code_dec = FB_REASON;
    end else if (cnt == '0) begin
      code_dec = FB_EMPTY;
    end else if (sovf) begin
      code_dec = FB_COUNT;
    end else begin
      code_dec = FB_NONE;
    end
  end

  always_comb begin
    sra   = i[IW-1:0];
    dra   = j[IW-1:0];
    swe   = 1'b0;
    swa   = cnt[IW-1:0];
    swd   = q_item.rect;
    dwe   = 1'b0;
    dwa   = m[IW-1:0];
    dwd   = cur;
    q_pop = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_pop = !q_empty;
        swe   = !q_empty && q_item.store && (32'(cnt) < MAX_RECTS);
      end
      S_SRD: begin
        if (j == '0) begin
          swe = 1'b1;
          swa = '0;
          swd = key;
        end else begin
          sra = jm1[IW-1:0];
        end
      end
      S_SCMP: begin
        swe = 1'b1;
        swa = j[IW-1:0];
        swd = less ? src_rd : key;
      end
      S_PSCAN: begin
        dwe = (j == m);
      end
      S_PSHIFT: begin
        if (kp1 < m) begin
          dra = kp1[IW-1:0];
        end else begin
          dwe = 1'b1;
          dwa = mm1[IW-1:0];
        end
      end
      S_PSHW: begin
        dwe = 1'b1;
        dwa = k[IW-1:0];
        dwd = dst_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      sovf   <= 1'b0;
      lme    <= 1'b0;
      ovalid <= 1'b0;
      s      <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.store) begin
              if (32'(cnt) < MAX_RECTS) cnt <= cnt + 1'b1;
              else sovf <= 1'b1;
            end
            if (q_item.lme) lme <= 1'b1;
            if (q_item.last) begin
              ev_force  <= q_item.force_req;
              ev_ovf    <= q_item.ovf_rec;
              ev_reason <= q_item.reason;
              state     <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          n    <= cnt;
          cnt  <= '0;
          sovf <= 1'b0;
          lme  <= 1'b0;
          s    <= 1'b0;
          i    <= CNTW'(1);
          code <= code_dec;
          state <= (code_dec != FB_NONE) ? S_FULL : S_SK;
        end
        S_SK: begin
          if (i == n) begin
            i       <= '0;
            m       <= '0;
            changed <= 1'b0;
            state   <= S_PRD;
          end else begin
            state <= S_SKW;
          end
        end
        S_SKW: begin
          key   <= src_rd;
          j     <= i;
          state <= S_SRD;
        end
        S_SRD: begin
          if (j == '0) begin
            i     <= i + 1'b1;
            state <= S_SK;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (less) begin
            j     <= jm1;
            state <= S_SRD;
          end else begin
            i     <= i + 1'b1;
            state <= S_SK;
          end
        end
        S_PRD: begin
          state <= (i == n) ? S_PEND : S_PCUR;
        end
        S_PCUR: begin
          cur   <= src_rd;
          j     <= '0;
          state <= S_PSCAN;
        end
        S_PSCAN: begin
          if (j == m) begin
            m     <= m + 1'b1;
            i     <= i + 1'b1;
            state <= S_PRD;
          end else begin
            state <= S_PHIT;
          end
        end
        S_PHIT: begin
          if (hit) begin
            cur     <= rect_union(cur, dst_rd);
            changed <= 1'b1;
            k       <= j;
            state   <= S_PSHIFT;
          end else begin
            j     <= j + 1'b1;
            state <= S_PSCAN;
          end
        end
        S_PSHIFT: begin
          if (kp1 < m) begin
            state <= S_PSHW;
          end else begin
            i     <= i + 1'b1;
            state <= S_PRD;
          end
        end
        S_PSHW: begin
          k     <= kp1;
          state <= S_PSHIFT;
        end
        S_PEND: begin
          n <= m;
          s <= !s;
          i <= '0;
          if (changed) begin
            m       <= '0;
            changed <= 1'b0;
            state   <= S_PRD;
          end else if (too_many) begin
            code  <= FB_COUNT;
            state <= S_FULL;
          end else begin
            cov   <= '0;
            state <= S_CRD;
          end
        end
        S_CRD: begin
          state <= (i == n) ? S_AR1 : S_CMUL;
        end
        S_CMUL: begin
          prod  <= 28'(src_rd.r - src_rd.l) * 28'(src_rd.b - src_rd.t);
          state <= S_CACC;
        end
        S_CACC: begin
          cov   <= cov + COVW'(prod);
          i     <= i + 1'b1;
          state <= S_CRD;
        end
        S_AR1: begin
          area  <= 28'(cfg.width) * 28'(cfg.height);
          state <= S_AR2;
        end
        S_AR2: begin
          thr_area <= 46'(cfg.thr) * 46'(area);
          state    <= S_CMP;
        end
        S_CMP: begin
          if (cov_hit) begin
            code  <= FB_COVERAGE;
            state <= S_FULL;
          end else begin
            i     <= '0;
            state <= S_ERD;
          end
        end
        S_FULL: begin
          if (ofree) begin
            out_left      <= '0;
            out_top       <= '0;
            out_right     <= cfg.width;
            out_bottom    <= cfg.height;
            out_last      <= 1'b1;
            full_frame    <= 1'b1;
            fallback_code <= code;
            s             <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_ERD: begin
          state <= S_EWR;
        end
        S_EWR: begin
          if (ofree) begin
            out_left      <= src_rd.l;
            out_top       <= src_rd.t;
            out_right     <= src_rd.r;
            out_bottom    <= src_rd.b;
            out_last      <= (i + 1'b1 == n);
            full_frame    <= 1'b0;
            fallback_code <= FB_NONE;
            i             <= i + 1'b1;
            if (i + 1'b1 == n) begin
              s     <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DRC_ASSERT_ALWAYS(a_cnt_range, 32'(cnt) <= MAX_RECTS)
  `DRC_ASSERT_IMPL(a_scan_bounds, state == S_PSCAN, (j <= m) && (m <= i))
  `DRC_ASSERT_NEXT(a_event_clear, state == S_DECIDE, (cnt == '0) && !sovf && !lme)

endmodule

>>> hw/rtl/dirty_rect_coalescer_top.sv
// Top level of the dirty rect coalescer: configuration registers and the
// front end, item queue and back end. Depends on drc_pkg, drc_front, drc_queue, drc_back.
//
// Usage: items (one dirty rect each) enter through push/full; an item is taken
// at a clock edge with push high and full low. The front end clips the rect
// into monitor space and drops it into a 4-entry queue, so input runs at one
// item per cycle while the back end is loading. Non-last items give no result.
// On the last item the back end, unless a fallback code is due, sorts the
// stored rects (insertion sort) and repeats merge passes (rect-pair compares,
// plus shifts) until a pass merges nothing, then runs a coverage scan over
// the rects and the area math. Results then leave one at a time through the
// empty/pop output register. A stalled receiver holds the back end; the
// queue then fills and full rises. Synchronous reset clears the store count,
// the store-overflow and mode-error flags and output valid and loads the
// default configuration. The config port writes one register per cycle and
// must be used only while idle; the block itself does not enforce this.
module dirty_rect_coalescer_top import drc_pkg::*; #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [2:0]                   cfg_index,
  input  logic [17:0]                  cfg_data,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic signed [COORD_BITS-1:0] rect_right,
  input  logic signed [COORD_BITS-1:0] rect_bottom,
  input  logic                         has_rect,
  input  logic                         last_rect,
  input  logic                         desktop_coords,
  input  logic                         explicit_target,
  input  logic                         force_request,
  input  logic                         overflow_recovery,
  input  logic [1:0]                   present_reason,
  input  logic                         push,
  output logic                         full,
  output logic [13:0]                  out_left,
  output logic [13:0]                  out_top,
  output logic [13:0]                  out_right,
  output logic [13:0]                  out_bottom,
  output logic                         out_last,
  output logic                         full_frame,
  output logic [2:0]                   fallback_code,
  output logic                         empty,
  input  logic                         pop
);

  logic [13:0]        monitor_width, monitor_height;
  logic signed [15:0] monitor_origin_x, monitor_origin_y;
  logic               merge_touching;
  logic [5:0]         max_rect_count;
  logic [17:0]        coverage_threshold;

  back_cfg_t bcfg;
  item_t     f_item, q_head;
  logic      f_push, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_width      <= 14'd1920;
      monitor_height     <= 14'd1080;
      monitor_origin_x   <= '0;
      monitor_origin_y   <= '0;
      merge_touching     <= 1'b1;
      max_rect_count     <= 6'd16;
      coverage_threshold <= 18'd49152;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:     monitor_width      <= cfg_data[13:0];
        REG_HEIGHT:    monitor_height     <= cfg_data[13:0];
        REG_ORIGIN_X:  monitor_origin_x   <= cfg_data[15:0];
        REG_ORIGIN_Y:  monitor_origin_y   <= cfg_data[15:0];
        REG_TOUCH:     merge_touching     <= cfg_data[0];
        REG_MAX_COUNT: max_rect_count     <= cfg_data[5:0];
        REG_COV_THR:   coverage_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    bcfg.width   = monitor_width;
    bcfg.height  = monitor_height;
    bcfg.touch   = merge_touching;
    bcfg.max_cnt = max_rect_count;
    bcfg.thr     = coverage_threshold;
  end

  assign full = q_full;

  drc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .rect_left         (rect_left),
    .rect_top          (rect_top),
    .rect_right        (rect_right),
    .rect_bottom       (rect_bottom),
    .has_rect          (has_rect),
    .last_rect         (last_rect),
    .desktop_coords    (desktop_coords),
    .explicit_target   (explicit_target),
    .force_request     (force_request),
    .overflow_recovery (overflow_recovery),
    .present_reason    (present_reason),
    .mon_width         (monitor_width),
    .mon_height        (monitor_height),
    .mon_ox            (monitor_origin_x),
    .mon_oy            (monitor_origin_y),
    .push              (push),
    .q_full            (q_full),
    .q_push            (f_push),
    .q_item            (f_item)
  );

  drc_queue #(.DEPTH(4)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  drc_back #(.MAX_RECTS(MAX_RECTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (bcfg),
    .q_item        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_left      (out_left),
    .out_top       (out_top),
    .out_right     (out_right),
    .out_bottom    (out_bottom),
    .out_last      (out_last),
    .full_frame    (full_frame),
    .fallback_code (fallback_code),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

>>> tb/sv/dirty_rect_coalescer_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for dirty_rect_coalescer_top: directed table, then random frames
// under several flow-control modes, checked against a behavioral coalescer. Depends on drc_pkg.
module dirty_rect_coalescer_top_test;
  import drc_pkg::*;

  localparam logic [1:0] REASON_INVALIDATE = 2'd0;
  localparam logic [1:0] REASON_RESERVED   = 2'd3;
  localparam int         STORE_DEPTH       = 32;

  typedef struct {
    logic signed [15:0] l, t, r, b;
    bit has, last, desk, expl, frc, ovf;
    logic [1:0] reason;
  } dirty_item_t;

  typedef struct {
    logic [13:0] l, t, r, b;
    bit last, ff;
    logic [2:0] code;
  } redraw_t;

  typedef struct { longint l, t, r, b; } box_t;

  typedef struct {
    dirty_item_t it;
    bit typed;
    redraw_t want;
  } table_row_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = REG_WIDTH;
  logic [17:0] cfg_data = '0;
  logic signed [15:0] rect_left = 0, rect_top = 0, rect_right = 0, rect_bottom = 0;
  logic has_rect = 0, last_rect = 0, desktop_coords = 0, explicit_target = 0;
  logic force_request = 0, overflow_recovery = 0;
  logic [1:0] present_reason = REASON_INVALIDATE;
  logic push = 0, pop = 0;
  logic full, empty, out_last, full_frame;
  logic [13:0] out_left, out_top, out_right, out_bottom;
  logic [2:0] fallback_code;

  dirty_rect_coalescer_top DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // shadow configuration and store
  longint mon_w = 1920, mon_h = 1080, org_x = 0, org_y = 0;
  bit     touch = 1;
  longint max_cnt = 16, cov_thr = 49152;
  box_t   stash [STORE_DEPTH];
  int     stash_n = 0;
  bit     stash_ovf = 0, mode_err = 0;

  redraw_t pending_redraws[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cyc = 0, hold_until = 0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic queue_redraw(input redraw_t rd);
    pending_redraws = {pending_redraws, rd};
  endtask

  function automatic longint lmin(longint a, longint b); return a < b ? a : b; endfunction
  function automatic longint lmax(longint a, longint b); return a > b ? a : b; endfunction

  function automatic bit box_less(box_t a, box_t b);
    if (a.t != b.t) return a.t < b.t;
    if (a.l != b.l) return a.l < b.l;
    if (a.b != b.b) return a.b < b.b;
    return a.r < b.r;
  endfunction

  function automatic bit box_hits(box_t a, box_t b);
    if (touch) return a.l <= b.r && b.l <= a.r && a.t <= b.b && b.t <= a.b;
    return a.l < b.r && b.l < a.r && a.t < b.b && b.t < a.b;
  endfunction

  task automatic merge_stash();
    box_t key, cur;
    box_t nxt [STORE_DEPTH];
    int j, m, n;
    bit changed;
    n = stash_n;
    for (int i = 1; i < n; i++) begin
      key = stash[i];
      j = i;
      while (j > 0 && box_less(key, stash[j-1])) begin
        stash[j] = stash[j-1];
        j--;
      end
      stash[j] = key;
    end
    changed = 1;
    while (changed) begin
      changed = 0;
      m = 0;
      for (int i = 0; i < n; i++) begin
        cur = stash[i];
        for (j = 0; j < m; j++) begin
          if (box_hits(cur, nxt[j])) begin
            cur.l = lmin(cur.l, nxt[j].l);
            cur.t = lmin(cur.t, nxt[j].t);
            cur.r = lmax(cur.r, nxt[j].r);
            cur.b = lmax(cur.b, nxt[j].b);
            for (int k = j; k + 1 < m; k++) nxt[k] = nxt[k+1];
            m--;
            changed = 1;
            break;
          end
        end
        nxt[m++] = cur;
      end
      for (int i = 0; i < m; i++) stash[i] = nxt[i];
      n = m;
    end
    stash_n = n;
  endtask

  task automatic predict_redraws(input dirty_item_t it);
    box_t bx;
    bit ok;
    logic [2:0] code;
    longint unsigned area, cov;
    redraw_t rd;
    code = FB_NONE;
    if (it.has) begin
      ok = 1;
      if (it.desk) begin
        bx.l = lmax(it.l, org_x) - org_x;
        bx.t = lmax(it.t, org_y) - org_y;
        bx.r = lmin(it.r, org_x + mon_w) - org_x;
        bx.b = lmin(it.b, org_y + mon_h) - org_y;
      end else if (it.expl) begin
        bx.l = lmax(0, it.l);
        bx.t = lmax(0, it.t);
        bx.r = lmin(mon_w, it.r);
        bx.b = lmin(mon_h, it.b);
      end else begin
        mode_err = 1;
        ok = 0;
      end
      if (ok && bx.l < bx.r && bx.t < bx.b) begin
        if (stash_n < STORE_DEPTH) stash[stash_n++] = bx;
        else stash_ovf = 1;
      end
    end
    if (!it.last) return;
    if (mode_err) code = FB_EMPTY;
    else if (it.frc) code = FB_INTENT;
    else if (it.ovf) code = FB_OVERFLOW;
    else if (it.reason == REASON_TOPOLOGY || it.reason == REASON_RECOVERY) code = FB_REASON;
    else if (stash_n == 0) code = FB_EMPTY;
    else if (stash_ovf) code = FB_COUNT;
    if (code == FB_NONE) begin
      merge_stash();
      if (stash_n > max_cnt || stash_n > OUT_LIMIT) begin
        code = FB_COUNT;
      end else begin
        area = mon_w * mon_h;
        cov = 0;
        for (int i = 0; i < stash_n; i++)
          cov += (stash[i].r - stash[i].l) * (stash[i].b - stash[i].t);
        if (area == 0) begin
          if (cov_thr == 0) code = FB_COVERAGE;
        end else if (cov * 65536 >= cov_thr * area) begin
          code = FB_COVERAGE;
        end
      end
    end
    if (code != FB_NONE) begin
      rd = '{14'd0, 14'd0, mon_w[13:0], mon_h[13:0], 1'b1, 1'b1, code};
      queue_redraw(rd);
    end else begin
      for (int i = 0; i < stash_n; i++) begin
        rd = '{stash[i].l[13:0], stash[i].t[13:0], stash[i].r[13:0], stash[i].b[13:0],
               i + 1 == stash_n, 1'b0, FB_NONE};
        queue_redraw(rd);
      end
    end
    stash_n = 0;
    stash_ovf = 0;
    mode_err = 0;
  endtask

  // result side
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  always @(posedge clk) begin
    redraw_t e;
    if (!rst && pop && !empty) begin
      if (pending_redraws.size() == 0) begin
        report("result with nothing pending");
      end else begin
        e = pending_redraws.pop_front();
        if (out_left !== e.l || out_top !== e.t || out_right !== e.r ||
            out_bottom !== e.b || out_last !== e.last || full_frame !== e.ff ||
            fallback_code !== e.code)
          report($sformatf("got %0d,%0d,%0d,%0d last%0b ff%0b code%0d want %0d,%0d,%0d,%0d last%0b ff%0b code%0d",
                 out_left, out_top, out_right, out_bottom, out_last, full_frame, fallback_code,
                 e.l, e.t, e.r, e.b, e.last, e.ff, e.code));
      end
    end
    if (rst || cyc < hold_until) pop <= 0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // item side; called just after a rising edge
  task automatic send_item(input dirty_item_t it);
    rect_left <= it.l;
    rect_top <= it.t;
    rect_right <= it.r;
    rect_bottom <= it.b;
    has_rect <= it.has;
    last_rect <= it.last;
    desktop_coords <= it.desk;
    explicit_target <= it.expl;
    force_request <= it.frc;
    overflow_recovery <= it.ovf;
    present_reason <= it.reason;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val[17:0];
    @(posedge clk);
    case (idx)
      REG_WIDTH:     mon_w = val & 14'h3fff;
      REG_HEIGHT:    mon_h = val & 14'h3fff;
      REG_ORIGIN_X:  org_x = longint'($signed(val[15:0]));
      REG_ORIGIN_Y:  org_y = longint'($signed(val[15:0]));
      REG_TOUCH:     touch = val[0];
      REG_MAX_COUNT: max_cnt = val & 6'h3f;
      REG_COV_THR:   cov_thr = val & 18'h3ffff;
      default: ;
    endcase
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending_redraws.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic configure(input longint w, h, ox, oy, tch, mx, thr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_TOUCH, tch);
    write_reg(REG_MAX_COUNT, mx);
    write_reg(REG_COV_THR, thr);
    cfg_write <= 0;
  endtask

  function automatic logic signed [15:0] clamp16(longint v);
    return 16'(lmax(-32768, lmin(32767, v)));
  endfunction

  // one random item; mostly well-formed rects near the monitor
  function automatic dirty_item_t rand_item(bit last, int span);
    dirty_item_t it;
    longint bx, by;
    it.has = ($urandom_range(99) < 95);
    it.last = last;
    it.desk = ($urandom_range(99) < 60);
    it.expl = it.desk ? 1'($urandom_range(1)) : ($urandom_range(99) < 92);
    it.frc = last && ($urandom_range(99) < 5);
    it.ovf = last && ($urandom_range(99) < 5);
    it.reason = ($urandom_range(99) < 88) ? REASON_INVALIDATE : 2'($urandom_range(3));
    if ($urandom_range(99) < 8) begin
      it.l = 16'($urandom); it.t = 16'($urandom);
      it.r = 16'($urandom); it.b = 16'($urandom);
    end else begin
      bx = (it.desk ? org_x : 0) + $urandom_range(0, 2 * span) - span / 4;
      by = (it.desk ? org_y : 0) + $urandom_range(0, 2 * span) - span / 4;
      it.l = clamp16(bx);
      it.t = clamp16(by);
      it.r = clamp16(bx + $urandom_range(0, span / 2) - 2);
      it.b = clamp16(by + $urandom_range(0, span / 2) - 2);
    end
    return it;
  endfunction

  task automatic send_frame(input int n, input int span);
    dirty_item_t it;
    for (int i = 0; i < n; i++) begin
      it = rand_item(i == n - 1, span);
      predict_redraws(it);
      send_item(it);
    end
  endtask

  task automatic random_phase(input int items, input int span);
    int n, sent;
    sent = 0;
    send_frame(36, span * 4);
    while (sent < items) begin
      n = $urandom_range(1, 6);
      send_frame(n, span);
      sent += n;
    end
  endtask

  function automatic table_row_t row(longint l, t, r, b, bit has, last, desk, expl, frc, ovf,
                                     logic [1:0] rsn, bit typed = 0,
                                     logic [2:0] code = FB_NONE);
    table_row_t x;
    x.it = '{clamp16(l), clamp16(t), clamp16(r), clamp16(b), has, last, desk, expl, frc, ovf,
             rsn};
    x.typed = typed;
    x.want = '{14'd0, 14'd0, 14'd1920, 14'd1080, 1'b1, 1'b1, code};
    return x;
  endfunction

  table_row_t dir_rows[$];

  initial begin
    int before_n;
    dir_rows = '{
      row(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, REASON_INVALIDATE, 1, FB_EMPTY),
      row(10, 10, 20, 20, 1, 1, 1, 0, 0, 0, REASON_INVALIDATE),
      row(10, 10, 20, 20, 1, 1, 1, 0, 1, 0, REASON_INVALIDATE, 1, FB_INTENT),
      row(10, 10, 20, 20, 1, 1, 1, 0, 0, 1, REASON_INVALIDATE, 1, FB_OVERFLOW),
      row(10, 10, 20, 20, 1, 1, 1, 0, 0, 0, REASON_TOPOLOGY, 1, FB_REASON),
      row(10, 10, 20, 20, 1, 1, 1, 0, 0, 0, REASON_RECOVERY, 1, FB_REASON),
      row(5, 6, 70, 80, 1, 1, 1, 1, 0, 0, REASON_RESERVED),
      row(1, 1, 9, 9, 1, 1, 0, 0, 1, 0, REASON_TOPOLOGY, 1, FB_EMPTY),
      row(-5, -5, 30, 30, 1, 0, 0, 1, 0, 0, REASON_INVALIDATE),
      row(30, 0, 50, 30, 1, 1, 0, 1, 0, 0, REASON_INVALIDATE),
      row(-32768, -32768, 32767, 32767, 1, 1, 1, 0, 0, 0, REASON_INVALIDATE, 1, FB_COVERAGE),
      row(32767, 32767, -32768, -32768, 1, 1, 1, 1, 0, 0, REASON_INVALIDATE, 1, FB_EMPTY),
      row(3000, 2000, 3100, 2100, 1, 1, 1, 0, 0, 0, REASON_INVALIDATE, 1, FB_EMPTY),
      row(100, 100, 200, 200, 1, 0, 1, 0, 0, 0, REASON_INVALIDATE),
      row(150, 150, 300, 250, 1, 0, 0, 1, 0, 0, REASON_INVALIDATE),
      row(400, 90, 500, 120, 1, 0, 1, 1, 0, 0, REASON_INVALIDATE),
      row(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, REASON_INVALIDATE),
      row(1900, 1070, 1920, 1080, 1, 1, 1, 0, 0, 0, REASON_INVALIDATE)
    };
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      before_n = pending_redraws.size();
      predict_redraws(dir_rows[i].it);
      if (dir_rows[i].typed) begin
        while (pending_redraws.size() > before_n) void'(pending_redraws.pop_back());
        queue_redraw(dir_rows[i].want);
      end
      send_item(dir_rows[i].it);
    end
    drain();

    // no idling; receiver held off while frames keep coming
    configure(1920, 1080, 0, 0, 1, 16, 49152);
    hold_until = cyc + 800;
    for (int f = 0; f < 4; f++) send_frame(8, 400);
    random_phase(20, 600);
    drain();

    send_idle_pct = 86;
    configure(16383, 16383, -32768, 32767, 0, 32, 131072);
    random_phase(25, 2000);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 86;
    configure(640, 480, 100, -50, 1, 3, 20000);
    random_phase(25, 300);
    drain();

    send_idle_pct = 10;
    recv_stall_pct = 10;
    configure(800, 600, 32767, -32768, 0, 8, 0);
    random_phase(15, 300);
    drain();

    configure(0, 5, -20, 20, 1, 0, 0);
    random_phase(10, 100);
    drain();

    if (errors == 0) $display("dirty_rect_coalescer_top: match");
    else $display("dirty_rect_coalescer_top: mismatch");
    $finish;
  end

  initial begin
    #8000000;
    $display("dirty_rect_coalescer_top: mismatch");
    $finish;
  end

endmodule

>>> dirty_rect_coalescer_top.f
+incdir+hw/rtl
hw/rtl/drc_pkg.sv
hw/rtl/drc_ram.sv
hw/rtl/drc_front.sv
hw/rtl/drc_queue.sv
hw/rtl/drc_back.sv
hw/rtl/dirty_rect_coalescer_top.sv
tb/sv/dirty_rect_coalescer_top_test.sv
